FILE: rtl/array_list_search_insert_delete_unit_assert.svh
// assertion macros for the list search/insert/delete unit
`ifndef ARRAY_LIST_SEARCH_INSERT_DELETE_UNIT_ASSERT_SVH
`define ARRAY_LIST_SEARCH_INSERT_DELETE_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define ALSID_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ALSID_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/alsid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsid_pkg
// shared constants, codes and command struct of the list search/insert/delete unit
// ----------------------------------------------------------------------------
package alsid_pkg;

	localparam int DEPTH   = 16;
	localparam int VALUE_W = 32;
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 5;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_SEARCH = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_DELETE = 2'd2
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_BAD_POS   = 2'd3
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;     // capture the request beat
		logic compare;  // register match vector result
		logic commit;   // apply update and register the result
	} dp_cmd_t;

endpackage

FILE: rtl/alsid_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsid_datapath
// entry registers, parallel compare, neighbor shifts and result registers
// ----------------------------------------------------------------------------
module alsid_datapath import alsid_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	input  logic [KIND_W-1:0]   kind,
	input  logic [VALUE_W-1:0]  value,
	input  logic [CNT_W-1:0]    position,
	input  logic [CNT_W-1:0]    capacity_limit,
	output logic                done,
	output logic                hit,
	output logic [IDX_W-1:0]    result_index,
	output logic [CNT_W-1:0]    entry_count,
	output logic [STAT_W-1:0]   status
);

	logic [VALUE_W-1:0] entries_q [DEPTH];
	logic [VALUE_W-1:0] entries_d [DEPTH];
	logic [VALUE_W-1:0] prev_e    [DEPTH];
	logic [VALUE_W-1:0] next_e    [DEPTH];
	logic [CNT_W-1:0]   count_q, count_d;

	logic [KIND_W-1:0]  kind_q;
	logic [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]   position_q;

	logic               found;
	logic [IDX_W-1:0]   first_idx;
	logic               match_q;
	logic [IDX_W-1:0]   match_idx_q;

	logic [CNT_W-1:0]   eff_limit;
	logic               is_full;
	logic               pos_ok;
	logic               do_insert, do_delete;

	logic               res_hit;
	logic [IDX_W-1:0]   res_idx;
	status_t            res_status;

	logic               done_q;
	logic               hit_q;
	logic [IDX_W-1:0]   result_index_q;
	logic [CNT_W-1:0]   entry_count_q;
	status_t            status_q;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= kind;
			value_q    <= value;
			position_q <= position;
		end
	end

	// neighbor taps
	for (genvar g = 0; g < DEPTH; g++) begin : g_nb
		if (g == 0) begin : g_first
			assign prev_e[g] = '0;
		end else begin : g_prev
			assign prev_e[g] = entries_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign next_e[g] = '0;
		end else begin : g_next
			assign next_e[g] = entries_q[g+1];
		end
	end

	// parallel compare over live slots, lowest index wins
	always_comb begin
		found     = 1'b0;
		first_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < count_q) && (entries_q[i] == value_q)) begin
				found     = 1'b1;
				first_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			match_q     <= found;
			match_idx_q <= first_idx;
		end
	end

	// request checks
	assign eff_limit = (capacity_limit > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity_limit;
	assign is_full   = count_q >= eff_limit;
	assign pos_ok    = (position_q != '0) &&
	                   ({1'b0, position_q} <= ({1'b0, count_q} + (CNT_W+1)'(1)));

	always_comb begin
		do_insert  = 1'b0;
		do_delete  = 1'b0;
		res_hit    = 1'b0;
		res_idx    = '0;
		res_status = STAT_OK;
		unique case (kind_q)
			KIND_SEARCH: begin
				res_hit    = match_q;
				res_idx    = match_q ? match_idx_q : '0;
				res_status = match_q ? STAT_OK : STAT_NOT_FOUND;
			end
			KIND_INSERT: begin
				if (is_full) begin
					res_status = STAT_FULL;
				end else if (!pos_ok) begin
					res_status = STAT_BAD_POS;
				end else begin
					do_insert = 1'b1;
				end
			end
			KIND_DELETE: begin
				res_hit    = match_q;
				res_idx    = match_q ? match_idx_q : '0;
				res_status = match_q ? STAT_OK : STAT_NOT_FOUND;
				do_delete  = match_q;
			end
			default: begin
			end
		endcase
	end

	// next entries: shift right above the insert slot, left above the deleted one
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			entries_d[i] = entries_q[i];
			if (do_insert) begin
				if (CNT_W'(i) == position_q - CNT_W'(1)) begin
					entries_d[i] = value_q;
				end else if ((CNT_W'(i) >= position_q) && (CNT_W'(i) <= count_q)) begin
					entries_d[i] = prev_e[i];
				end
			end else if (do_delete) begin
				if ((CNT_W'(i) >= {1'b0, match_idx_q}) && (CNT_W'(i + 1) < count_q)) begin
					entries_d[i] = next_e[i];
				end else if (CNT_W'(i) == count_q - CNT_W'(1)) begin
					entries_d[i] = '0;
				end
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (do_insert) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_delete) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < DEPTH; i++) begin
				entries_q[i] <= entries_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit) begin
				count_q <= count_d;
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q          <= res_hit;
			result_index_q <= res_idx;
			entry_count_q  <= count_d;
			status_q       <= res_status;
		end
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign result_index = result_index_q;
	assign entry_count  = entry_count_q;
	assign status       = status_q;

endmodule

FILE: rtl/alsid_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsid_ctrl
// request sequencer: capture, compare, commit
// ----------------------------------------------------------------------------
`include "array_list_search_insert_delete_unit_assert.svh"

module alsid_ctrl import alsid_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	// a new beat may enter while the previous one commits
	assign busy   = (state_q == S_CMP);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = accept ? S_CMP : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.load    = accept;
	assign cmd.compare = (state_q == S_CMP);
	assign cmd.commit  = (state_q == S_EXEC);

	`ALSID_ASSERT(a_load_then_cmp, cmd.load |=> cmd.compare, "load not followed by compare")
	`ALSID_ASSERT(a_cmp_then_exec, cmd.compare |=> cmd.commit, "compare not followed by commit")
	`ALSID_NEVER(a_no_load_in_cmp, cmd.load && cmd.compare, "beat taken during compare")

endmodule

FILE: rtl/array_list_search_insert_delete_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_search_insert_delete_unit
// ordered list of up to 16 signed 32-bit values with search, insert, delete
// ----------------------------------------------------------------------------
// usage
//   request channel: drive kind, value, position with start; a beat is taken
//   at the clock edge where start is high and busy is low
//   result channel: done is high for one cycle with hit, result_index,
//   entry_count and status; the receiver cannot stall, so it must take it
//   latency: result shows 2 cycles after the accepting edge (compare cycle,
//   then the commit cycle that also loads the output registers) and is
//   taken at the edge after that
//   throughput: one beat every 2 cycles; busy is high only in the compare
//   cycle, since the 16-slot match vector must be registered before the
//   shift that commits the update
//   config: APB write of capacity_limit at byte address 0, only while idle;
//   reads return the current value, pready is tied high
//   reset: count clears to zero, capacity_limit to 16, no beat in flight;
//   entry storage is not cleared, slots above the count are never compared
// ----------------------------------------------------------------------------
module array_list_search_insert_delete_unit import alsid_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// request beat
	input  logic                      start,
	output logic                      busy,
	input  logic [KIND_W-1:0]         kind,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [CNT_W-1:0]          position,
	// result beat
	output logic                      done,
	output logic                      hit,
	output logic [IDX_W-1:0]          result_index,
	output logic [CNT_W-1:0]          entry_count,
	output logic [STAT_W-1:0]         status,
	// configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	dp_cmd_t          cmd;
	logic [CNT_W-1:0] capacity_limit_q;
	logic             cfg_wr;

	// apb: zero-wait, only register 0 is implemented
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_limit_q <= CNT_W'(DEPTH);
		end else if (cfg_wr) begin
			capacity_limit_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, capacity_limit_q} : '0;

	// sequencer
	alsid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// storage, compare and result registers
	alsid_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.kind           (kind),
		.value          (value),
		.position       (position),
		.capacity_limit (capacity_limit_q),
		.done           (done),
		.hit            (hit),
		.result_index   (result_index),
		.entry_count    (entry_count),
		.status         (status)
	);

endmodule
